FILE: design/lrupr_pkg.sv
// ----------------------------------------------------------------------------
// lrupr_pkg
// Shared types and constants for the LRU page replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package lrupr_pkg;

  localparam int PAGE_W      = 16;
  localparam int CFG_W       = 5;
  localparam int SLOT_OUT_W  = 4;
  localparam int TOTAL_W     = 16;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 40;

  localparam logic [CFG_W-1:0]   FRAME_COUNT_RST = 5'd16;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX       = 16'hFFFF;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } lrupr_state_e;

  // one result transaction
  typedef struct packed {
    logic                  fault;
    logic [SLOT_OUT_W-1:0] frame_slot;
    logic                  evicted_valid;
    logic [PAGE_W-1:0]     evicted_page;
    logic [TOTAL_W-1:0]    fault_total;
  } lrupr_result_t;

endpackage

`default_nettype wire

FILE: design/lrupr_frame_mem.sv
// ----------------------------------------------------------------------------
// lrupr_frame_mem
// Frame table memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_frame_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 20
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/lrupr_engine.sv
// ----------------------------------------------------------------------------
// lrupr_engine
// Sequencer: scans the frame table for a hit and the oldest frame, decides
// hit, fill or eviction, then sweeps the table to update the recency ranks.
// ----------------------------------------------------------------------------
`default_nettype none

module lrupr_engine
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAME_SLOTS = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [PAGE_W-1:0] page_i,
  input  wire logic              last_i,
  input  wire logic [CFG_W-1:0]  frame_count_i,
  output logic                   idle_o,
  output logic                   res_valid_o,
  input  wire logic              res_ready_i,
  output lrupr_result_t          res_o
);

  localparam int SLOT_W = (MAX_FRAME_SLOTS > 1) ? $clog2(MAX_FRAME_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_FRAME_SLOTS + 1);
  localparam int ENT_W  = PAGE_W + SLOT_W;
  localparam int CMP_W  = CFG_W + 2;

  lrupr_state_e state_q, state_d;

  logic [CNT_W-1:0]   idx_q, n_q, active_q, filled_q;
  logic [TOTAL_W-1:0] fault_cnt_q;
  logic               last_q, hit_q, op_all_q, res_fault_q, res_evict_q;
  logic [PAGE_W-1:0]  page_q, vic_page_q;
  logic [SLOT_W-1:0]  hit_slot_q, hit_rank_q, vic_slot_q, vic_rank_q;
  logic [SLOT_W-1:0]  op_slot_q, op_limit_q;

  logic [CNT_W-1:0]   n_d, prev_idx;
  logic [SLOT_W-1:0]  prev_addr, rd_rank, new_rank;
  logic [PAGE_W-1:0]  rd_page;
  logic [CMP_W-1:0]   fc_wide;
  logic               mem_we, mem_re;
  logic [SLOT_W-1:0]  mem_waddr;
  logic [ENT_W-1:0]   mem_wdata, mem_rdata;
  logic [SLOT_W+SLOT_OUT_W-1:0] slot_ext;

  lrupr_frame_mem #(
    .DEPTH  (MAX_FRAME_SLOTS),
    .ADDR_W (SLOT_W),
    .DATA_W (ENT_W)
  ) u_frame_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (idx_q[SLOT_W-1:0]),
    .rdata_o (mem_rdata)
  );

  // clamp the frame count to 1..MAX_FRAME_SLOTS
  always_comb begin
    fc_wide = {2'b00, frame_count_i};
    if (frame_count_i == '0) begin
      n_d = CNT_W'(1);
    end else if (fc_wide > CMP_W'(MAX_FRAME_SLOTS)) begin
      n_d = CNT_W'(MAX_FRAME_SLOTS);
    end else begin
      n_d = CNT_W'(frame_count_i);
    end
  end

  // entry returning from the memory belongs to the previous index
  assign prev_idx  = CNT_W'(idx_q - CNT_W'(1));
  assign prev_addr = prev_idx[SLOT_W-1:0];
  assign rd_page   = mem_rdata[ENT_W-1:SLOT_W];
  assign rd_rank   = mem_rdata[SLOT_W-1:0];

  // memory access and rank update
  always_comb begin
    mem_re    = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = prev_addr;
    new_rank  = rd_rank;
    if (op_all_q || (rd_rank < op_limit_q)) begin
      new_rank = SLOT_W'(rd_rank + SLOT_W'(1));
    end
    mem_wdata = {rd_page, new_rank};
    if (prev_addr == op_slot_q) begin
      mem_wdata = {page_q, {SLOT_W{1'b0}}};
    end
    case (state_q)
      ST_SCAN:   mem_re = (idx_q < active_q);
      ST_UPDATE: begin
        mem_re = (idx_q < filled_q);
        mem_we = (idx_q != '0);
      end
      default:   mem_re = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (start_i) state_d = ST_SCAN;
      ST_SCAN:   if (idx_q == active_q) state_d = ST_DECIDE;
      ST_DECIDE: state_d = ST_UPDATE;
      ST_UPDATE: if (idx_q == filled_q) state_d = ST_DONE;
      ST_DONE:   if (res_ready_i) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      filled_q    <= '0;
      fault_cnt_q <= '0;
      hit_q       <= 1'b0;
      op_all_q    <= 1'b0;
      res_fault_q <= 1'b0;
      res_evict_q <= 1'b0;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          idx_q <= '0;
          hit_q <= 1'b0;
        end
        ST_SCAN: begin
          if ((idx_q != '0) && !hit_q && (rd_page == page_q)) begin
            hit_q <= 1'b1;
          end
          if (idx_q != active_q) begin
            idx_q <= CNT_W'(idx_q + CNT_W'(1));
          end
        end
        ST_DECIDE: begin
          idx_q <= '0;
          if (hit_q) begin
            op_all_q    <= 1'b0;
            res_fault_q <= 1'b0;
            res_evict_q <= 1'b0;
          end else begin
            res_fault_q <= 1'b1;
            if (fault_cnt_q != TOTAL_MAX) begin
              fault_cnt_q <= TOTAL_W'(fault_cnt_q + TOTAL_W'(1));
            end
            if (filled_q < n_q) begin
              op_all_q    <= 1'b1;
              res_evict_q <= 1'b0;
              filled_q    <= CNT_W'(filled_q + CNT_W'(1));
            end else begin
              op_all_q    <= 1'b0;
              res_evict_q <= 1'b1;
            end
          end
        end
        ST_UPDATE: begin
          if (idx_q != filled_q) begin
            idx_q <= CNT_W'(idx_q + CNT_W'(1));
          end
        end
        ST_DONE: begin
          if (res_ready_i && last_q) begin
            filled_q    <= '0;
            fault_cnt_q <= '0;
          end
        end
        default: idx_q <= '0;
      endcase
    end
  end

  // item and search payload
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          page_q   <= page_i;
          last_q   <= last_i;
          n_q      <= n_d;
          active_q <= (filled_q < n_d) ? filled_q : n_d;
        end
      end
      ST_SCAN: begin
        if (idx_q != '0) begin
          if (!hit_q && (rd_page == page_q)) begin
            hit_slot_q <= prev_addr;
            hit_rank_q <= rd_rank;
          end
          // oldest frame, lowest index wins a tie
          if ((prev_idx == '0) || (rd_rank > vic_rank_q)) begin
            vic_slot_q <= prev_addr;
            vic_rank_q <= rd_rank;
            vic_page_q <= rd_page;
          end
        end
      end
      ST_DECIDE: begin
        if (hit_q) begin
          op_slot_q  <= hit_slot_q;
          op_limit_q <= hit_rank_q;
        end else if (filled_q < n_q) begin
          op_slot_q  <= filled_q[SLOT_W-1:0];
          op_limit_q <= '0;
        end else begin
          op_slot_q  <= vic_slot_q;
          op_limit_q <= vic_rank_q;
        end
      end
      default: op_slot_q <= op_slot_q;
    endcase
  end

  // result
  assign slot_ext    = {{SLOT_OUT_W{1'b0}}, op_slot_q};
  assign idle_o      = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  always_comb begin
    res_o.fault         = res_fault_q;
    res_o.frame_slot    = slot_ext[SLOT_OUT_W-1:0];
    res_o.evicted_valid = res_evict_q;
    res_o.evicted_page  = res_evict_q ? vic_page_q : '0;
    res_o.fault_total   = fault_cnt_q;
  end

`ifndef NO_ASSERTIONS
  // table never holds more frames than exist
  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= CNT_W'(MAX_FRAME_SLOTS))
    else $error("filled frame count beyond table depth");

  // table is only written during the rank sweep
  a_write_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_UPDATE))
    else $error("frame table written outside update sweep");

  // a finished result waits until taken
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !res_ready_i) |=> (res_valid_o && $stable(res_o)))
    else $error("result dropped before it was taken");

  // a hit or a fill always lands inside the filled frames
  a_slot_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> (CNT_W'(op_slot_q) < filled_q))
    else $error("result slot outside the filled frames");
`endif

endmodule

`default_nettype wire

FILE: design/lru_page_replacement_top.sv
// ----------------------------------------------------------------------------
// lru_page_replacement_top
// LRU page replacement unit with stream ports and a frame count register.
// ----------------------------------------------------------------------------
// Flow: each input transaction runs a table scan over the searched frames, a
//   decide step and a rank sweep over the filled frames, the scan and the
//   sweep each one frame a cycle through the single read port. A new page is
//   taken only once the engine is idle again, after its result is handed on.
// Reset: frame count returns to 16, filled count and fault count clear; the
//   frame table is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_page_replacement_top
  import lrupr_pkg::*;
#(
  parameter int MAX_FRAME_SLOTS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // frame count register
  input  wire logic                   cfg_we_i,
  input  wire logic [CFG_W-1:0]       cfg_wdata_i,
  // page references
  input  wire logic                   s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [15:0] page
  input  wire logic                   s_axis_tlast_i,   // last_reference
  // results
  output logic                        m_axis_tvalid_o,
  input  wire logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata_o,   // [3:0] frame_slot,
                                                        // [4] evicted_valid,
                                                        // [20:5] evicted_page,
                                                        // [36:21] fault_total
  output logic                        m_axis_tuser_o    // fault
);

  logic [CFG_W-1:0] frame_count_q;
  logic             eng_idle, eng_start, res_valid, res_ready;
  lrupr_result_t    eng_res, out_res_q;
  logic             out_valid_q, out_valid_d;

  // frame count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= FRAME_COUNT_RST;
    end else if (cfg_we_i) begin
      frame_count_q <= cfg_wdata_i;
    end
  end

  // input transaction starts the engine
  assign s_axis_tready_o = eng_idle;
  assign eng_start       = s_axis_tvalid_i & eng_idle;

  lrupr_engine #(
    .MAX_FRAME_SLOTS (MAX_FRAME_SLOTS)
  ) u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (eng_start),
    .page_i        (s_axis_tdata_i[PAGE_W-1:0]),
    .last_i        (s_axis_tlast_i),
    .frame_count_i (frame_count_q),
    .idle_o        (eng_idle),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (eng_res)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= eng_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_res_q.fault;
  assign m_axis_tdata_o  = {3'b000, out_res_q.fault_total, out_res_q.evicted_page,
                            out_res_q.evicted_valid, out_res_q.frame_slot};

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU page replacement block. Page references
// go in as stream transactions, with bursts and gaps. Results are drained
// through a stalling receiver and compared field by field against an
// in-bench replacement tracker. The frame count is swept across its range
// while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import lrupr_pkg::*;

  localparam int          SLOTS        = 16;
  localparam int unsigned TAIL_CYCLES  = 2 * SLOTS + 8;
  localparam int unsigned HOLD_CYCLES  = 500;
  localparam int unsigned LIMIT_CYCLES = 400_000;

  // replacement tracker: mirrors frame table, recency ranks and fault count
  class lru_reference_tracker;
    logic [PAGE_W-1:0]  resident_page [SLOTS];
    logic [3:0]         age_rank [SLOTS];
    logic [4:0]         filled_count;
    logic [TOTAL_W-1:0] fault_count;
    logic [CFG_W-1:0]   frame_limit;
    lrupr_result_t      outcome_q [$];
    int unsigned        failures;
    int unsigned        reported;

    function new();
      frame_limit = FRAME_COUNT_RST;
      failures    = 0;
      reported    = 0;
      clear_table();
    endfunction

    function void clear_table();
      foreach (resident_page[i]) begin
        resident_page[i] = '0;
        age_rank[i]      = '0;
      end
      filled_count = '0;
      fault_count  = '0;
    endfunction

    // filled frames younger than limit age by one, slot becomes youngest
    function void make_youngest(int unsigned slot, int unsigned limit);
      for (int i = 0; i < filled_count && i < SLOTS; i++) begin
        if (age_rank[i] < limit) age_rank[i] = age_rank[i] + 4'd1;
      end
      age_rank[slot] = '0;
    endfunction

    function int unsigned pending();
      return outcome_q.size();
    endfunction

    // work out the result of one accepted reference
    function void note_reference(logic [PAGE_W-1:0] page, logic last_ref);
      int unsigned   n;
      int unsigned   searched;
      int unsigned   slot;
      bit            hit;
      lrupr_result_t res;
      n = 32'(frame_limit);
      if (n == 0) n = 1;
      if (n > SLOTS) n = SLOTS;
      searched = (32'(filled_count) < n) ? 32'(filled_count) : n;
      hit  = 1'b0;
      slot = 0;
      res  = '0;
      for (int i = 0; i < searched; i++) begin
        if (!hit && resident_page[i] == page) begin
          hit  = 1'b1;
          slot = i;
        end
      end
      if (hit) begin
        make_youngest(slot, age_rank[slot]);
      end else begin
        if (32'(filled_count) < n) begin
          // fill the next empty frame
          slot = 32'(filled_count);
          resident_page[slot] = page;
          age_rank[slot]      = '0;
          filled_count        = filled_count + 5'd1;
          make_youngest(slot, 'hFF);
        end else begin
          // evict the oldest searched frame, lowest index on a tie
          slot = 0;
          for (int i = 1; i < n; i++) begin
            if (age_rank[i] > age_rank[slot]) slot = i;
          end
          res.evicted_valid   = 1'b1;
          res.evicted_page    = resident_page[slot];
          resident_page[slot] = page;
          make_youngest(slot, age_rank[slot]);
        end
        if (fault_count != TOTAL_MAX) fault_count = fault_count + 16'd1;
      end
      res.fault       = !hit;
      res.frame_slot  = slot[SLOT_OUT_W-1:0];
      res.fault_total = fault_count;
      outcome_q.push_back(res);
      if (last_ref) clear_table();
    endfunction

    // compare one accepted result with the oldest expectation
    function void check_result(logic [OUT_TDATA_W-1:0] data, logic fault);
      lrupr_result_t got;
      lrupr_result_t exp;
      bit            bad;
      got.fault         = fault;
      got.frame_slot    = data[3:0];
      got.evicted_valid = data[4];
      got.evicted_page  = data[20:5];
      got.fault_total   = data[36:21];
      if (outcome_q.size() == 0) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result: fault=%0d slot=%0d ev=%0d ev_page=%h total=%0d",
                   got.fault, got.frame_slot, got.evicted_valid, got.evicted_page,
                   got.fault_total);
        end
        return;
      end
      exp = outcome_q.pop_front();
      bad = (got.fault !== exp.fault) || (got.frame_slot !== exp.frame_slot) ||
            (got.evicted_valid !== exp.evicted_valid) ||
            (got.evicted_page !== exp.evicted_page) ||
            (got.fault_total !== exp.fault_total);
      if (bad) begin
        failures++;
        if (reported < 10) begin
          reported++;
          $display("mismatch: expected fault=%0d slot=%0d ev=%0d ev_page=%h total=%0d",
                   exp.fault, exp.frame_slot, exp.evicted_valid, exp.evicted_page,
                   exp.fault_total);
          $display("          actual   fault=%0d slot=%0d ev=%0d ev_page=%h total=%0d",
                   got.fault, got.frame_slot, got.evicted_valid, got.evicted_page,
                   got.fault_total);
        end
      end
    endfunction
  endclass

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_we_i        = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata_i     = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;   // [15:0] page
  logic                   s_axis_tlast_i  = 1'b0; // last_reference
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;         // [3:0] frame_slot, [4] evicted_valid,
                                                  // [20:5] evicted_page,
                                                  // [36:21] fault_total
  logic                   m_axis_tuser_o;         // fault

  lru_reference_tracker tracker;

  int unsigned rx_mode       = 0;
  bit          tx_gaps       = 1'b0;
  int unsigned burst_left    = 0;
  int unsigned hold_requests = 0;
  int unsigned holds_served  = 0;
  int unsigned hold_left     = 0;
  int unsigned rx_cycle      = 0;
  int unsigned cycle_count   = 0;

  lru_page_replacement_top #(
    .MAX_FRAME_SLOTS (SLOTS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // clock, 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // result side: check accepted transactions, then pick next ready value
  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      tracker.check_result(m_axis_tdata_o, m_axis_tuser_o);
    end
    rx_cycle++;
    if (hold_requests != holds_served) begin
      holds_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      case (rx_mode)
        0:       m_axis_tready_i <= 1'b1;
        1:       m_axis_tready_i <= ($urandom_range(0, 3) != 0);
        2:       m_axis_tready_i <= ((rx_cycle % 11) >= 3);
        default: m_axis_tready_i <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // offer one reference and wait for its transaction
  task automatic send_reference(input logic [PAGE_W-1:0] page, input logic last_ref);
    if (tx_gaps && burst_left == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= page;
    s_axis_tlast_i  <= last_ref;
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_reference(page, last_ref);
    if (burst_left != 0) burst_left--;
  endtask

  // stop offering and wait until every expected result has come back
  task automatic wait_for_results();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_frame_count(input logic [CFG_W-1:0] value);
    wait_for_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    tracker.frame_limit = value;
  endtask

  // reference strings over a small working set, with stray pages mixed in;
  // most strings end with a last marker, the rest run into the next one
  task automatic run_reference_strings(input int unsigned count, input bit with_hold);
    logic [PAGE_W-1:0] working_set [$];
    logic [PAGE_W-1:0] page;
    int unsigned       sent;
    int unsigned       set_size;
    int unsigned       str_len;
    bit                closes;
    sent = 0;
    while (sent < count) begin
      working_set.delete();
      set_size = $urandom_range(1, 20);
      repeat (set_size) working_set.push_back(16'($urandom));
      str_len = $urandom_range(1, 40);
      closes  = ($urandom_range(0, 9) != 0);
      for (int k = 0; k < str_len; k++) begin
        if ($urandom_range(0, 6) == 0) page = 16'($urandom);
        else page = working_set[$urandom_range(0, set_size - 1)];
        // long receiver hold-off while references keep coming
        if (with_hold && sent == 20) hold_requests++;
        send_reference(page, closes && (k == str_len - 1));
        sent++;
      end
    end
  endtask

  // run limit
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // main sequence
  initial begin
    logic [CFG_W-1:0] fc;
    tracker = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset frame count: fills, hits on both extreme pages, last clears
    rx_mode = 1;
    tx_gaps = 1'b1;
    send_reference(16'h0000, 1'b0);
    send_reference(16'hFFFF, 1'b0);
    send_reference(16'h0000, 1'b0);
    send_reference(16'h5555, 1'b0);
    send_reference(16'hFFFF, 1'b0);
    send_reference(16'hAAAA, 1'b1);

    // zero frame count behaves as one frame
    write_frame_count(5'd0);
    send_reference(16'h0001, 1'b0);
    send_reference(16'h0001, 1'b0);
    send_reference(16'h8000, 1'b1);

    // count above the table size saturates, seventeenth page evicts
    write_frame_count(5'd31);
    rx_mode = 0;
    tx_gaps = 1'b0;
    for (int i = 0; i < 17; i++) send_reference(16'h0100 + 16'(i), 1'b0);

    // count lowered mid-string: upper frames neither searched nor replaced
    write_frame_count(5'd3);
    send_reference(16'h010A, 1'b0);
    send_reference(16'h0110, 1'b0);
    send_reference(16'h0102, 1'b1);

    // random phases across the frame count range
    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       fc = 5'd1;
        1:       fc = 5'd16;
        2:       fc = 5'd31;
        3:       fc = 5'd0;
        4:       fc = 5'($urandom_range(2, 15));
        5:       fc = 5'($urandom_range(17, 30));
        6:       fc = 5'($urandom_range(1, 6));
        default: fc = 5'($urandom_range(8, 16));
      endcase
      write_frame_count(fc);
      rx_mode = p % 4;
      tx_gaps = (p % 3 != 1);
      run_reference_strings(88, p == 2);
    end

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.failures == 0 && tracker.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
design/lrupr_pkg.sv
design/lrupr_frame_mem.sv
design/lrupr_engine.sv
design/lru_page_replacement_top.sv
tb/testbench.sv
